>>> src/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

    typedef struct packed {
        logic load_byte;
        logic [7:0] byte_val;
        logic start_block;
        logic round_step;
        logic finish_block;
        logic reset_chain;
    } sha_cmd_t;

    typedef logic [31:0] word_t;

    localparam int unsigned NumRounds = 64;

    function automatic word_t round_const(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenBytePos = 6'd56;

endpackage

`default_nettype wire

>>> src/sha256_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none

// SHA-256 hasher for a byte stream.
// Input transfers carry one byte in s_axis_tdata; s_axis_tuser[0] says the
// byte is valid and s_axis_tlast ends the message (it may come with or
// without a byte). Output transfers carry the eight digest words, word 0
// first, with the index in m_axis_tuser and tlast on word 7.
// A byte that does not complete a block is taken without a stall. The 64th
// byte of a block starts the compression: a setup step, 64 rounds (one round
// per cycle in a single shared round unit) and an update step, during which
// no input is taken.
// At message end the padding is written one byte per cycle up to the end of
// the block and compressed; when 0x80 falls at byte 56 or later, a second
// block of zeros and the length is written and compressed before the digest.
// The digest waits as long as m_axis_tready is low; no input is taken until
// all eight words are transferred and the clear state has passed, after
// which the chaining state, length and position are back at their reset
// values. aresetn clears all of these.
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tuser,   // has_byte
    input  wire logic        s_axis_tlast,   // msg_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // digest_word
    output logic [2:0]       m_axis_tuser,   // word_index
    output logic             m_axis_tlast    // last_word
);

    sha_cmd_t cmd;
    logic [5:0] round_idx;
    logic [2:0] out_idx;

    sha256_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_has    (s_axis_tuser),
        .in_end    (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_idx   (out_idx),
        .cmd       (cmd),
        .round_idx (round_idx)
    );

    sha256_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .round_idx (round_idx),
        .out_idx   (out_idx),
        .out_word  (m_axis_tdata)
    );

    assign m_axis_tuser = out_idx;
    assign m_axis_tlast = (out_idx == 3'd7);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output active together");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("digest output continued past last word");

    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1)
        else $error("digest word index did not advance");

endmodule

`default_nettype wire

>>> src/sha256_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sha256_datapath
    import sha256_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire sha_cmd_t cmd,
    input  wire logic [5:0] round_idx,
    input  wire logic [2:0] out_idx,
    output word_t         out_word
);

    word_t window_reg [16];
    word_t vars_reg [8];
    word_t chain_reg [8];

    word_t w_cur;
    word_t s0w;
    word_t s1w;
    word_t s1;
    word_t ch;
    word_t t1;
    word_t s0;
    word_t mj;
    logic [3:0] slot;

    always_comb begin
        slot = round_idx[3:0];
        s0w = {window_reg[slot + 4'd1][6:0], window_reg[slot + 4'd1][31:7]}
            ^ {window_reg[slot + 4'd1][17:0], window_reg[slot + 4'd1][31:18]}
            ^ (window_reg[slot + 4'd1] >> 3);
        s1w = {window_reg[slot + 4'd14][16:0], window_reg[slot + 4'd14][31:17]}
            ^ {window_reg[slot + 4'd14][18:0], window_reg[slot + 4'd14][31:19]}
            ^ (window_reg[slot + 4'd14] >> 10);
        if (round_idx < 6'd16) begin
            w_cur = window_reg[slot];
        end else begin
            w_cur = window_reg[slot] + s0w + window_reg[slot + 4'd9] + s1w;
        end
        s1 = {vars_reg[4][5:0], vars_reg[4][31:6]} ^ {vars_reg[4][10:0], vars_reg[4][31:11]}
            ^ {vars_reg[4][24:0], vars_reg[4][31:25]};
        ch = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        t1 = vars_reg[7] + s1 + ch + round_const(round_idx) + w_cur;
        s0 = {vars_reg[0][1:0], vars_reg[0][31:2]} ^ {vars_reg[0][12:0], vars_reg[0][31:13]}
            ^ {vars_reg[0][21:0], vars_reg[0][31:22]};
        mj = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
            ^ (vars_reg[1] & vars_reg[2]);
    end

    assign out_word = chain_reg[out_idx];

    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            window_reg[round_idx[5:2]] <= {window_reg[round_idx[5:2]][23:0], cmd.byte_val};
        end
        if (cmd.start_block) begin
            for (int i = 0; i < 8; i++) begin
                vars_reg[i] <= chain_reg[i];
            end
        end
        if (cmd.round_step) begin
            window_reg[slot] <= w_cur;
            vars_reg[7] <= vars_reg[6];
            vars_reg[6] <= vars_reg[5];
            vars_reg[5] <= vars_reg[4];
            vars_reg[4] <= vars_reg[3] + t1;
            vars_reg[3] <= vars_reg[2];
            vars_reg[2] <= vars_reg[1];
            vars_reg[1] <= vars_reg[0];
            vars_reg[0] <= t1 + s0 + mj;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reset_chain) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= init_hash(3'(i));
            end
        end else if (cmd.finish_block) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= chain_reg[i] + vars_reg[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> src/sha256_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic  in_has,
    input  wire logic  in_end,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [2:0] out_idx,
    output sha_cmd_t   cmd,
    output logic [5:0] round_idx
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_START,
        ST_ROUND,
        ST_FINISH,
        ST_OUT,
        ST_CLEAR
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] pos_reg, pos_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [63:0] len_reg, len_next;
    logic ending_reg, ending_next;
    logic [2:0] oidx_reg, oidx_next;
    logic [7:0] pad_byte;
    // An end marker on the byte that fills a block is remembered until the
    // block has been compressed.
    logic pend_end_reg, pend_end_next;
    // Set when 0x80 lands in the length field, so this block is only zero
    // filled and the length goes into one more block.
    logic wrap_reg, wrap_next;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_idx = oidx_reg;
    assign round_idx = (state_reg == ST_ROUND) ? rnd_reg[5:0] : pos_reg;

    always_comb begin
        if (!ending_reg) begin
            pad_byte = PadByte;
        end else if (pos_reg < LenBytePos || wrap_reg) begin
            pad_byte = 8'h00;
        end else begin
            pad_byte = len_reg[8 * (7 - 32'(pos_reg[2:0])) +: 8];
        end
    end

    always_comb begin
        state_next = state_reg;
        pos_next = pos_reg;
        rnd_next = rnd_reg;
        len_next = len_reg;
        ending_next = ending_reg;
        oidx_next = oidx_reg;
        wrap_next = wrap_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_has) begin
                        cmd.load_byte = 1'b1;
                        cmd.byte_val = in_byte;
                        pos_next = pos_reg + 6'd1;
                        len_next = len_reg + 64'd8;
                    end
                    // The pad pass begins with 0x80 (ending flag still clear).
                    if (in_has && pos_reg == 6'd63) begin
                        state_next = ST_START;
                    end else if (in_end) begin
                        state_next = ST_PAD;
                    end
                    if (in_end) begin
                        ending_next = 1'b0;
                    end
                end
            end
            ST_PAD: begin
                cmd.load_byte = 1'b1;
                cmd.byte_val = pad_byte;
                pos_next = pos_reg + 6'd1;
                ending_next = 1'b1;
                if (!ending_reg && pos_reg >= LenBytePos) begin
                    wrap_next = 1'b1;
                end
                if (pos_reg == 6'd63) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.start_block = 1'b1;
                rnd_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_step = 1'b1;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'(NumRounds - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish_block = 1'b1;
                rnd_next = '0;
                wrap_next = 1'b0;
                // Ending is set once the pad pass has written any byte.
                if (ending_reg && pos_reg == 6'd0 && !wrap_reg) begin
                    state_next = ST_OUT;
                    oidx_next = '0;
                end else if (ending_reg || pend_end_reg) begin
                    state_next = ST_PAD;
                    ending_next = pend_end_reg ? 1'b0 : ending_reg;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_ready) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.reset_chain = 1'b1;
                pos_next = '0;
                len_next = '0;
                ending_next = 1'b0;
                wrap_next = 1'b0;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pend_end_next = pend_end_reg;
        if (state_reg == ST_IDLE && in_valid && in_has && in_end && pos_reg == 6'd63) begin
            pend_end_next = 1'b1;
        end else if (state_reg == ST_FINISH) begin
            pend_end_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg <= '0;
            rnd_reg <= '0;
            len_reg <= '0;
            ending_reg <= 1'b0;
            oidx_reg <= '0;
            pend_end_reg <= 1'b0;
            wrap_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            rnd_reg <= rnd_next;
            len_reg <= len_next;
            ending_reg <= ending_next;
            oidx_reg <= oidx_next;
            pend_end_reg <= pend_end_next;
            wrap_reg <= wrap_next;
        end
    end

endmodule

`default_nettype wire

>>> dv/sha256_stream_hasher_tb.sv
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;
    import sha256_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       has;
        logic       fin;
        bit         chk;
        word_t      first;
    } stim_row_t;

    typedef struct {
        word_t      word;
        logic [2:0] idx;
        logic       last;
    } digest_word_t;

    localparam int WatchdogLimit = 4000;

    localparam word_t KConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t HStart [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    sha256_stream_hasher u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Predictor state: chaining words, the pending block and the bit count.
    word_t        hash_chain [8];
    logic [7:0]   blk_bytes [64];
    logic [5:0]   blk_fill;
    logic [63:0]  msg_bits;
    digest_word_t digest_q [$];

    int errors = 0;
    int items_sent = 0;
    int msgs_done = 0;
    int words_seen = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    int burst_left = 1;
    int stall_mode = 0;

    function automatic word_t ror(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void clear_hash();
        hash_chain = HStart;
        blk_fill = '0;
        msg_bits = '0;
    endfunction

    function automatic void compress_blk();
        word_t w [64];
        word_t v [8];
        word_t t1, t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            w[i] = w[i-16] + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        v = hash_chain;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KConst[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_chain[i] += v[i];
    endfunction

    function automatic void add_byte(logic [7:0] b);
        blk_bytes[blk_fill] = b;
        blk_fill++;
        if (blk_fill == 0) compress_blk();
    endfunction

    // Updates the predictor for one accepted input transfer.
    function automatic void hash_step(logic [7:0] data, logic has, logic fin);
        logic [63:0] len;
        digest_word_t dw;
        if (has) begin
            add_byte(data);
            msg_bits += 64'd8;
        end
        if (!fin) return;
        len = msg_bits;
        add_byte(PadByte);
        while (blk_fill != LenBytePos) add_byte(8'h00);
        for (int s = 56; s >= 0; s -= 8) add_byte(len[s +: 8]);
        for (int k = 0; k < 8; k++) begin
            dw.word = hash_chain[k];
            dw.idx = 3'(k);
            dw.last = (k == 7);
            digest_q = {digest_q, dw};
        end
        msgs_done++;
        clear_hash();
    endfunction

    task automatic send(logic [7:0] data, logic has, logic fin, bit chk = 0, word_t first = '0);
        while (gap_left > 0) begin
            s_axis_tvalid = 1'b0;
            gap_left--;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = data;
        s_axis_tuser = has;
        s_axis_tlast = fin;
        do @(posedge aclk); while (!s_axis_tready);
        hash_step(data, has, fin);
        if (chk && digest_q[digest_q.size()-8].word !== first) begin
            $error("predicted digest_word expected %h actual %h",
                   first, digest_q[digest_q.size()-8].word);
            errors++;
        end
        @(negedge aclk);
        if (--burst_left <= 0) begin
            burst_left = $urandom_range(1, 14);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The receiver picks a new stall pattern at random intervals.
    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        digest_word_t exp_w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            words_seen++;
            if (digest_q.size() == 0) begin
                $error("unexpected digest transfer %h", m_axis_tdata);
                errors++;
            end else begin
                exp_w = digest_q.pop_front();
                if (m_axis_tdata !== exp_w.word) begin
                    $error("digest_word expected %h actual %h", exp_w.word, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== exp_w.idx) begin
                    $error("word_index expected %0d actual %0d", exp_w.idx, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== exp_w.last) begin
                    $error("last_word expected %b actual %b", exp_w.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else if (++idle_cycles >= WatchdogLimit) begin
            $display("watchdog expired with %0d words pending", digest_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    stim_row_t dir_rows [13] = '{
        '{8'h00, 1'b0, 1'b1, 1, 32'he3b0c442},  // empty message
        '{8'h5a, 1'b0, 1'b0, 0, '0},            // neither byte nor end
        '{8'h61, 1'b1, 1'b0, 0, '0},
        '{8'h62, 1'b1, 1'b0, 0, '0},
        '{8'h63, 1'b1, 1'b1, 1, 32'hba7816bf},  // "abc", last byte with the end
        '{8'hff, 1'b1, 1'b0, 0, '0},
        '{8'h00, 1'b1, 1'b0, 0, '0},
        '{8'hff, 1'b1, 1'b0, 0, '0},
        '{8'h00, 1'b0, 1'b0, 0, '0},
        '{8'h00, 1'b0, 1'b1, 0, '0},            // empty ending after bytes
        '{8'h00, 1'b1, 1'b1, 0, '0},
        '{8'hff, 1'b1, 1'b1, 0, '0},
        '{8'ha5, 1'b0, 1'b1, 1, 32'he3b0c442}   // data ignored without has_byte
    };

    initial begin
        int len, sel;
        logic fin_on_byte;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b1;
        clear_hash();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            send(dir_rows[i].data, dir_rows[i].has, dir_rows[i].fin,
                 dir_rows[i].chk, dir_rows[i].first);
        end

        // Whole messages with random content; lengths are mostly short, with some around block edges.
        while (items_sent < 160) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) len = $urandom_range(0, 12);
            else if (sel == 6) len = $urandom_range(54, 57);
            else if (sel == 7) len = $urandom_range(62, 66);
            else if (sel == 8) len = $urandom_range(118, 121);
            else len = $urandom_range(1, 3);
            if (len > 160 - items_sent) len = 160 - items_sent;
            fin_on_byte = (len > 0) && $urandom_range(0, 1);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 6) == 0) begin
                    send(8'($urandom), 1'b0, 1'b0);
                    items_sent++;
                end
                send(8'($urandom), 1'b1, fin_on_byte && (i == len - 1));
                items_sent++;
            end
            if (!fin_on_byte) begin
                send(8'($urandom), 1'b0, 1'b1);
                items_sent++;
            end
        end
        s_axis_tvalid = 1'b0;

        while (digest_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Hashed %0d messages over %0d random and directed byte transfers,",
                 msgs_done, items_sent + $size(dir_rows));
        $display("checking %0d digest words under random source gaps and sink stalls.",
                 words_seen);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
